[sv/bvs_pkg.sv]
// ============================================================================
// bvs_pkg
// Types and constants shared by the bounded vector store front end,
// back end and top level.
// ============================================================================
`default_nettype none

package bvs_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned KindBits  = 3;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned PosBits   = 4;
  localparam int unsigned LenBits   = 5;
  localparam int unsigned CapBits   = 5;

  // Operation codes, as carried in the kind field
  typedef enum logic [KindBits-1:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_READ_AT   = 3'd2,
    OP_READ_LAST = 3'd3,
    OP_ASSIGN    = 3'd4,
    OP_RESIZE    = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_FIND      = 3'd7
  } op_e;

  // Decoded request handed from front to back through the queue
  typedef struct packed {
    op_e                  op;
    logic [ValueBits-1:0] value;
    logic [PosBits-1:0]   pos;
    logic [LenBits-1:0]   len;
  } req_t;

  // One result item
  typedef struct packed {
    logic [ValueBits-1:0] read_value;
    logic                 hit;
    logic [PosBits-1:0]   found_position;
    logic                 status;
    logic [LenBits-1:0]   count;
    logic                 is_full;
    logic                 is_empty;
  } resp_t;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // Effective capacity: zero acts as one, anything above lim acts as lim
  function automatic logic [CapBits-1:0] cap_clamp(input logic [CapBits-1:0] raw,
                                                    input logic [CapBits-1:0] lim);
    logic [CapBits-1:0] c;
    c = raw;
    if (c == '0) begin
      c = CapBits'(1);
    end
    if (c > lim) begin
      c = lim;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/bvs_front.sv]
// ============================================================================
// bvs_front
// Accepts requests, decodes the kind and holds them in a two-entry queue.
// ============================================================================
`default_nettype none

module bvs_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic [bvs_pkg::KindBits-1:0]  kind_i,
  input  wire logic [bvs_pkg::ValueBits-1:0] value_i,
  input  wire logic [bvs_pkg::PosBits-1:0]   pos_i,
  input  wire logic [bvs_pkg::LenBits-1:0]   len_i,
  output logic                               q_valid_o,
  output bvs_pkg::req_t                      q_req_o,
  input  wire logic                          q_pop_i
);

  bvs_pkg::req_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          push;
  bvs_pkg::req_t req_in;

  // kind maps one to one onto the op codes
  always_comb begin
    req_in.op    = bvs_pkg::op_e'(kind_i);
    req_in.value = value_i;
    req_in.pos   = pos_i;
    req_in.len   = len_i;
  end

  assign s_ready_o = (fill_q != 2'd2);
  assign push      = s_valid_i && s_ready_o;
  assign q_valid_o = (fill_q != 2'd0);
  assign q_req_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !q_pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (!push && q_pop_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_in;
    end
  end

  // back end only pops a queued request
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

[sv/bvs_back.sv]
// ============================================================================
// bvs_back
// Executes queued requests against the entry memory and fill count and
// holds the result in an output register.
// ============================================================================
`default_nettype none

module bvs_back #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bvs_pkg::CapBits-1:0] cfg_wdata_i,
  input  wire logic                        q_valid_i,
  input  wire bvs_pkg::req_t               q_req_i,
  output logic                             q_pop_o,
  output logic                             m_valid_o,
  input  wire logic                        m_ready_i,
  output bvs_pkg::resp_t                   m_resp_o
);

  // Entries past 31 can never be reached: capacity register is 5 bits
  localparam int unsigned MemDepth = (DEPTH < 32) ? DEPTH : 32;
  localparam int unsigned AW       = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned CapMax   = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [bvs_pkg::CapBits-1:0] CapMaxC = bvs_pkg::CapBits'(CapMax);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [bvs_pkg::CapBits-1:0]   cap_q;
  logic [bvs_pkg::CapBits-1:0]   cap_eff, cap_new;
  logic [bvs_pkg::LenBits-1:0]   cnt_q, cnt_d, cnt_next;
  logic [bvs_pkg::LenBits-1:0]   scan_q, scan_d, scan_nx;
  logic [bvs_pkg::LenBits-1:0]   pos5;
  bvs_pkg::req_t                 cur_q, cur_d;

  logic [WORD_BITS-1:0] mem [MemDepth];
  logic [MemDepth-1:0]  valid_q;
  logic [WORD_BITS-1:0] rd_q, rd_word;
  logic                 rdv_q;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;

  logic                 out_valid_q, out_free, load;
  bvs_pkg::resp_t       out_q, resp;

  assign cap_eff  = bvs_pkg::cap_clamp(cap_q, CapMaxC);
  assign cap_new  = bvs_pkg::cap_clamp(cfg_wdata_i, CapMaxC);
  assign out_free = !out_valid_q || m_ready_i;
  assign rd_word  = rdv_q ? rd_q : '0;
  assign pos5     = {1'b0, q_req_i.pos};
  assign scan_nx  = scan_q + 5'd1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    cur_d   = cur_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = WORD_BITS'(q_req_i.value);
    rd_addr = '0;
    resp    = '0;
    resp.status = bvs_pkg::STATUS_DONE;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          cur_d   = q_req_i;
          case (q_req_i.op)
            bvs_pkg::OP_PUSH: begin
              load = 1'b1;
              if (cnt_q >= cap_eff) begin
                resp.status = bvs_pkg::STATUS_REJECTED;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(cnt_q);
                cnt_d   = cnt_q + 5'd1;
              end
            end
            bvs_pkg::OP_POP: begin
              load = 1'b1;
              if (cnt_q == '0) begin
                resp.status = bvs_pkg::STATUS_REJECTED;
              end else begin
                cnt_d = cnt_q - 5'd1;
              end
            end
            bvs_pkg::OP_READ_AT: begin
              if (pos5 >= cnt_q) begin
                load        = 1'b1;
                resp.status = bvs_pkg::STATUS_REJECTED;
              end else begin
                rd_addr = AW'(q_req_i.pos);
                state_d = ST_READ;
              end
            end
            bvs_pkg::OP_READ_LAST: begin
              if (cnt_q == '0) begin
                load        = 1'b1;
                resp.status = bvs_pkg::STATUS_REJECTED;
              end else begin
                rd_addr = AW'(cnt_q - 5'd1);
                state_d = ST_READ;
              end
            end
            bvs_pkg::OP_ASSIGN: begin
              load = 1'b1;
              if (pos5 >= cap_eff) begin
                resp.status = bvs_pkg::STATUS_REJECTED;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(q_req_i.pos);
                if (pos5 >= cnt_q) begin
                  cnt_d = pos5 + 5'd1;
                end
              end
            end
            bvs_pkg::OP_RESIZE: begin
              load = 1'b1;
              if (q_req_i.len > cap_eff) begin
                resp.status = bvs_pkg::STATUS_REJECTED;
              end else begin
                cnt_d = q_req_i.len;
              end
            end
            bvs_pkg::OP_CLEAR: begin
              load  = 1'b1;
              cnt_d = '0;
            end
            default: begin // find
              if (cnt_q == '0) begin
                load = 1'b1;
              end else begin
                rd_addr = '0;
                scan_d  = '0;
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        load            = 1'b1;
        resp.read_value = bvs_pkg::ValueBits'(rd_word);
        state_d         = ST_IDLE;
      end

      ST_SCAN: begin
        if (rd_word == WORD_BITS'(cur_q.value)) begin
          load                = 1'b1;
          resp.hit            = 1'b1;
          resp.found_position = bvs_pkg::PosBits'(scan_q);
          state_d             = ST_IDLE;
        end else if (scan_nx >= cnt_q) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rd_addr = AW'(scan_nx);
          scan_d  = scan_nx;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    resp.count    = cnt_d;
    resp.is_full  = (cnt_d == cap_eff);
    resp.is_empty = (cnt_d == '0);
  end

  // capacity writes cut the count down to the new limit
  always_comb begin
    cnt_next = cnt_d;
    if (cfg_we_i && (cnt_q > cap_new)) begin
      cnt_next = cap_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= bvs_pkg::CapBits'(16);
      cnt_q       <= '0;
      scan_q      <= '0;
      valid_q     <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_next;
      scan_q  <= scan_d;
      rdv_q   <= valid_q[rd_addr];
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q  <= mem[rd_addr];
    cur_q <= cur_d;
    if (load) begin
      out_q <= resp;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_resp_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapMaxC)
    else $error("fill count beyond largest capacity");

  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_valid_q)
    else $error("result pending while a multi-cycle op runs");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> (out_q.status == bvs_pkg::STATUS_DONE))
    else $error("find hit reported as rejected");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.is_full && out_q.is_empty))
    else $error("result both full and empty");

endmodule

`default_nettype wire

[sv/bounded_vector_store_core.sv]
// ============================================================================
// bounded_vector_store_core
// Fixed-capacity vector of words with a fill count: push, pop, read at,
// read last, assign, resize, clear and find, one result per request.
// ============================================================================
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  --------------------------------
//  s_axis    in   tvalid_i / tready_o        tuser: kind; tdata: value,
//                                            position, new_length
//  m_axis    out  tvalid_o / tready_i        tdata: result fields
//  cfg       in   we_i (no wait)             wdata: capacity_in_use
//
//  Request to result register: push, pop, assign, resize and clear load
//  it directly; read at and read last pass through a read state
//  (registered memory read); find scans one entry per cycle from the
//  single memory read port and stops at the first match or the count.
//  A two-entry queue decouples the input side from execution, so requests
//  are taken while a result waits on a stalled m_axis.
//  Reset clears the fill count, sets capacity to 16 and clears the per-entry
//  valid bits; an entry never written reads as zero. No clearing pass.
//  Capacity writes are expected only while the block is idle.
// ============================================================================
`default_nettype none

module bounded_vector_store_core #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] item_value, [35:32] position, [40:36] new_length, [47:41] zero
  input  wire logic [47:0] s_axis_tdata_i,
  // [2:0] kind
  input  wire logic [2:0]  s_axis_tuser_i,
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [31:0] read_value, [32] hit, [36:33] found_position, [37] status,
  // [42:38] count, [43] is_full, [44] is_empty, [47:45] zero
  output logic [47:0]      m_axis_tdata_o,
  // capacity register
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  logic           q_valid;
  logic           q_pop;
  bvs_pkg::req_t  q_req;
  bvs_pkg::resp_t resp;

  // front: decode and queue
  bvs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .kind_i    (s_axis_tuser_i),
    .value_i   (s_axis_tdata_i[31:0]),
    .pos_i     (s_axis_tdata_i[35:32]),
    .len_i     (s_axis_tdata_i[40:36]),
    .q_valid_o (q_valid),
    .q_req_o   (q_req),
    .q_pop_i   (q_pop)
  );

  // back: execution against entry memory, result register
  bvs_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_resp_o    (resp)
  );

  // pack result fields, read_value in the lowest bits
  assign m_axis_tdata_o = {3'b000,
                           resp.is_empty,
                           resp.is_full,
                           resp.count,
                           resp.status,
                           resp.found_position,
                           resp.hit,
                           resp.read_value};

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ============================================================================
// tb_top - bounded vector store core testbench
// A directed table, then random traffic over ten capacity settings, runs
// through the request stream. Each accepted request updates a shadow copy of
// the store, and every result transfer is compared field by field with the
// oldest prediction. Both stream sides back off at random.
// ============================================================================

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth   = 16;
  localparam int unsigned ClkHalf      = 10;
  localparam int unsigned SettleCycles = 24;     // > longest find scan plus queue
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned RandPhases   = 10;
  localparam int unsigned PhaseOps     = 110;

  localparam logic StDone = bvs_pkg::STATUS_DONE;
  localparam logic StRej  = bvs_pkg::STATUS_REJECTED;

  // One request as queued for the stream driver. Rows whose outcome is
  // obvious carry a hand-written result; the rest use the shadow store.
  typedef struct {
    bvs_pkg::req_t  req;
    bit             typed;
    bvs_pkg::resp_t want;
  } feed_t;

  // Directed table row: either a capacity write or a request
  typedef struct {
    bit         cap_write;
    logic [4:0] cap_value;
    feed_t      item;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;  // [31:0] value, [35:32] pos, [40:36] len
  logic [2:0]  s_axis_tuser_i  = '0;  // [2:0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;        // [31:0] read_value .. [44] is_empty
  logic        cfg_we_i        = 1'b0;
  logic [4:0]  cfg_wdata_i     = '0;

  bounded_vector_store_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Shadow store: words, fill count and the raw capacity register
  // --------------------------------------------------------------------------
  logic [31:0] shadow_words [StoreDepth];
  logic [4:0]  shadow_fill;
  logic [4:0]  shadow_cap;

  feed_t          feed_q[$];           // requests waiting for the driver
  bvs_pkg::resp_t pending_results[$];  // predictions waiting for a result transfer
  dir_row_t       dir_rows[$];
  logic [31:0]    value_pool [6];      // small pool so finds hit and duplicate

  bit          holding      = 1'b0; // a request is on the bus, not yet taken
  int unsigned idle_pct     = 27;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned n_checked    = 0;
  int unsigned n_hits       = 0;
  int unsigned n_rejected   = 0;
  int unsigned n_directed   = 0;
  int unsigned n_cap_writes = 0;

  // register value 0 acts as 1, anything above the depth acts as the depth
  function automatic logic [4:0] effective_capacity();
    if (shadow_cap == 5'd0) begin
      return 5'd1;
    end
    if (shadow_cap > StoreDepth) begin
      return 5'(StoreDepth);
    end
    return shadow_cap;
  endfunction

  // Apply one operation to the shadow store and return its result transfer
  function automatic bvs_pkg::resp_t predict_store_op(bvs_pkg::req_t rq);
    bvs_pkg::resp_t r;
    logic [4:0]     cap;
    cap = effective_capacity();
    r   = '0;
    case (rq.op)
      bvs_pkg::OP_PUSH: begin
        if (shadow_fill >= cap) begin
          r.status = StRej;
        end else begin
          shadow_words[shadow_fill] = rq.value;
          shadow_fill = shadow_fill + 5'd1;
        end
      end
      bvs_pkg::OP_POP: begin
        if (shadow_fill == 5'd0) begin
          r.status = StRej;
        end else begin
          shadow_fill = shadow_fill - 5'd1;  // word stays in place
        end
      end
      bvs_pkg::OP_READ_AT: begin
        if (rq.pos >= shadow_fill) begin
          r.status = StRej;
        end else begin
          r.read_value = shadow_words[rq.pos];
        end
      end
      bvs_pkg::OP_READ_LAST: begin
        if (shadow_fill == 5'd0) begin
          r.status = StRej;
        end else begin
          r.read_value = shadow_words[shadow_fill - 5'd1];
        end
      end
      bvs_pkg::OP_ASSIGN: begin
        if (rq.pos >= cap) begin
          r.status = StRej;
        end else begin
          // writing past the end grows the count first
          if (rq.pos >= shadow_fill) begin
            shadow_fill = rq.pos + 5'd1;
          end
          shadow_words[rq.pos] = rq.value;
        end
      end
      bvs_pkg::OP_RESIZE: begin
        if (rq.len > cap) begin
          r.status = StRej;
        end else begin
          shadow_fill = rq.len;
        end
      end
      bvs_pkg::OP_CLEAR: begin
        shadow_fill = 5'd0;
      end
      bvs_pkg::OP_FIND: begin
        // walk downward so the lowest match is the one kept
        for (int i = int'(shadow_fill) - 1; i >= 0; i--) begin
          if (shadow_words[i] == rq.value) begin
            r.hit            = 1'b1;
            r.found_position = 4'(i);
          end
        end
      end
    endcase
    r.count    = shadow_fill;
    r.is_full  = (shadow_fill == cap);
    r.is_empty = (shadow_fill == 5'd0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting
  // --------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("result %0d: %s got 0x%0h, want 0x%0h",
                             n_checked, name, got, want));
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side: one transfer per handshake; tvalid holds until taken.
  // The prediction is made at the accepting edge, in stream order.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    feed_t          cur_item;
    bvs_pkg::resp_t predicted;
    if (rst_ni) begin
      if (holding && s_axis_tvalid_i && s_axis_tready_o) begin
        predicted = predict_store_op(cur_item.req);
        pending_results.push_back(cur_item.typed ? cur_item.want : predicted);
        holding = 1'b0;
      end
      if (!holding && feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        cur_item = feed_q.pop_front();
        holding  = 1'b1;
        s_axis_tdata_i <= {7'd0, cur_item.req.len, cur_item.req.pos, cur_item.req.value};
        s_axis_tuser_i <= cur_item.req.op;
      end
      s_axis_tvalid_i <= holding;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, compare against oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : collect_results
    bvs_pkg::resp_t got;
    bvs_pkg::resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.read_value     = m_axis_tdata_o[31:0];
        got.hit            = m_axis_tdata_o[32];
        got.found_position = m_axis_tdata_o[36:33];
        got.status         = m_axis_tdata_o[37];
        got.count          = m_axis_tdata_o[42:38];
        got.is_full        = m_axis_tdata_o[43];
        got.is_empty       = m_axis_tdata_o[44];
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("result transfer with nothing outstanding (tdata 0x%0h)",
                                 m_axis_tdata_o));
        end else begin
          want = pending_results.pop_front();
          check_field("read_value", got.read_value, want.read_value);
          check_field("hit", 32'(got.hit), 32'(want.hit));
          check_field("found_position", 32'(got.found_position), 32'(want.found_position));
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("count", 32'(got.count), 32'(want.count));
          check_field("is_full", 32'(got.is_full), 32'(want.is_full));
          check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
          n_checked++;
          if (want.hit) n_hits++;
          if (want.status == StRej) n_rejected++;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("bounded_vector_store_core: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  // everything sent and answered, then let the core settle
  task automatic wait_idle();
    while (feed_q.size() != 0 || holding || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // only called while idle; a lower capacity trims the count right away
  task automatic write_capacity(input logic [4:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    shadow_cap = value;
    if (shadow_fill > effective_capacity()) begin
      shadow_fill = effective_capacity();
    end
    n_cap_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bvs_pkg::resp_t outcome(logic [31:0] rd, logic hit, logic [3:0] fpos,
                                             logic st, logic [4:0] cnt, logic full,
                                             logic empty);
    bvs_pkg::resp_t r;
    r.read_value     = rd;
    r.hit            = hit;
    r.found_position = fpos;
    r.status         = st;
    r.count          = cnt;
    r.is_full        = full;
    r.is_empty       = empty;
    return r;
  endfunction

  function automatic void add_op(bvs_pkg::op_e op, logic [31:0] value, logic [3:0] pos,
                                 logic [4:0] len);
    dir_row_t row;
    row = '{cap_write: 1'b0, cap_value: 5'd0, item: '{req: '0, typed: 1'b0, want: '0}};
    row.item.req.op    = op;
    row.item.req.value = value;
    row.item.req.pos   = pos;
    row.item.req.len   = len;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked(bvs_pkg::op_e op, logic [31:0] value,
                                      logic [3:0] pos, logic [4:0] len,
                                      bvs_pkg::resp_t want);
    add_op(op, value, pos, len);
    dir_rows[$].item.typed = 1'b1;
    dir_rows[$].item.want  = want;
  endfunction

  function automatic void add_cap(logic [4:0] value);
    dir_row_t row;
    row = '{cap_write: 1'b1, cap_value: value, item: '{req: '0, typed: 1'b0, want: '0}};
    dir_rows.push_back(row);
  endfunction

  // Random request, steered by the shadow state so most traffic lands in
  // range: pushes while room is left, reads inside the count, assigns in
  // the capacity, finds for stored words. A share stays out of range on purpose.
  function automatic feed_t random_request();
    feed_t       f;
    logic [4:0]  cnt;
    logic [4:0]  cap;
    int unsigned roll;
    int unsigned push_w;
    cnt = shadow_fill;
    cap = effective_capacity();
    f.typed     = 1'b0;
    f.want      = '0;
    f.req.value = ($urandom_range(3) == 0) ? $urandom : value_pool[$urandom_range(5)];
    f.req.pos   = 4'($urandom_range(15));
    f.req.len   = 5'($urandom_range(31));
    push_w = (cnt < cap) ? 30 : 8;
    roll   = $urandom_range(99);
    if (roll < push_w) begin
      f.req.op = bvs_pkg::OP_PUSH;
    end else if (roll < push_w + 12) begin
      f.req.op = bvs_pkg::OP_POP;
    end else if (roll < push_w + 26) begin
      f.req.op = bvs_pkg::OP_READ_AT;
      if (cnt != 0 && $urandom_range(5) != 0) f.req.pos = 4'($urandom_range(cnt - 1));
    end else if (roll < push_w + 34) begin
      f.req.op = bvs_pkg::OP_READ_LAST;
    end else if (roll < push_w + 46) begin
      f.req.op = bvs_pkg::OP_ASSIGN;
      if ($urandom_range(4) != 0) f.req.pos = 4'($urandom_range(cap - 1));
    end else if (roll < push_w + 54) begin
      f.req.op = bvs_pkg::OP_RESIZE;
      if ($urandom_range(4) != 0) f.req.len = 5'($urandom_range(cap));
    end else if (roll < push_w + 57) begin
      f.req.op = bvs_pkg::OP_CLEAR;
    end else begin
      f.req.op = bvs_pkg::OP_FIND;
      if (cnt != 0 && $urandom_range(9) < 7) begin
        f.req.value = shadow_words[$urandom_range(cnt - 1)];
      end
    end
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [4:0] cap_v;
    for (int i = 0; i < StoreDepth; i++) shadow_words[i] = '0;
    shadow_fill = 5'd0;
    shadow_cap  = 5'd16;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) value_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, starting from the reset capacity of 16.
    // Empty-store rejects, find and clear on an empty store
    add_checked(bvs_pkg::OP_POP,       32'h0, 4'd0,  5'd0,
                outcome(0, 0, 0, StRej, 0, 0, 1));
    add_checked(bvs_pkg::OP_READ_LAST, 32'h0, 4'd0,  5'd0,
                outcome(0, 0, 0, StRej, 0, 0, 1));
    add_checked(bvs_pkg::OP_READ_AT,   32'h0, 4'd15, 5'd0,
                outcome(0, 0, 0, StRej, 0, 0, 1));
    add_checked(bvs_pkg::OP_FIND,      32'h0, 4'd0,  5'd0,
                outcome(0, 0, 0, StDone, 0, 0, 1));
    add_checked(bvs_pkg::OP_CLEAR,     32'h0, 4'd0,  5'd0,
                outcome(0, 0, 0, StDone, 0, 0, 1));
    // value extremes, assign past count grows it to full, push on full
    add_checked(bvs_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd0, 5'd0,
                outcome(0, 0, 0, StDone, 1, 0, 0));
    add_op(bvs_pkg::OP_PUSH, 32'h0000_0000, 4'd0, 5'd0);
    add_checked(bvs_pkg::OP_READ_AT, 32'h0, 4'd0, 5'd0,
                outcome(32'hFFFF_FFFF, 0, 0, StDone, 2, 0, 0));
    add_checked(bvs_pkg::OP_ASSIGN, 32'hA5A5_A5A5, 4'd15, 5'd0,
                outcome(0, 0, 0, StDone, 16, 1, 0));
    add_checked(bvs_pkg::OP_PUSH, 32'h1, 4'd0, 5'd0,
                outcome(0, 0, 0, StRej, 16, 1, 0));
    add_op(bvs_pkg::OP_READ_LAST, 32'h0, 4'd0, 5'd0);
    add_op(bvs_pkg::OP_FIND, 32'h0000_0000, 4'd0, 5'd0);   // zero sits at 1..14, lowest wins
    add_op(bvs_pkg::OP_FIND, 32'hA5A5_A5A5, 4'd0, 5'd0);
    // resize above capacity, to the same length, shrink and regrow
    add_checked(bvs_pkg::OP_RESIZE, 32'h0, 4'd0, 5'd17,
                outcome(0, 0, 0, StRej, 16, 1, 0));
    add_op(bvs_pkg::OP_RESIZE, 32'h0, 4'd0, 5'd31);
    add_op(bvs_pkg::OP_RESIZE, 32'h0, 4'd0, 5'd16);
    add_op(bvs_pkg::OP_POP, 32'h0, 4'd0, 5'd0);
    add_op(bvs_pkg::OP_READ_AT, 32'h0, 4'd15, 5'd0);         // just past the count
    add_op(bvs_pkg::OP_RESIZE, 32'h0, 4'd0, 5'd16);
    add_op(bvs_pkg::OP_READ_AT, 32'h0, 4'd15, 5'd0);         // old word is back
    add_op(bvs_pkg::OP_RESIZE, 32'h0, 4'd0, 5'd0);
    add_op(bvs_pkg::OP_ASSIGN, 32'h1234_5678, 4'd3, 5'd0);
    // capacity below the count trims it; assign at capacity is rejected
    add_cap(5'd2);
    add_op(bvs_pkg::OP_READ_LAST, 32'h0, 4'd0, 5'd0);
    add_op(bvs_pkg::OP_ASSIGN, 32'hDEAD_BEEF, 4'd2, 5'd0);
    // zero acts as one, above depth acts as depth
    add_cap(5'd0);
    add_op(bvs_pkg::OP_PUSH, 32'h5555_5555, 4'd0, 5'd0);
    add_cap(5'd31);
    add_op(bvs_pkg::OP_RESIZE, 32'h0, 4'd0, 5'd16);
    add_op(bvs_pkg::OP_CLEAR, 32'h0, 4'd0, 5'd0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cap_write) begin
        wait_idle();
        write_capacity(dir_rows[i].cap_value);
      end else begin
        feed_q.push_back(dir_rows[i].item);
        n_directed++;
      end
    end

    // Random phases, each at its own capacity; one runs without any idling
    for (int p = 0; p < RandPhases; p++) begin
      wait_idle();
      case (p)
        0: cap_v = 5'd16;
        1: cap_v = 5'd1;
        2: cap_v = 5'd5;
        3: cap_v = 5'd0;
        4: cap_v = 5'd31;
        5: cap_v = 5'd9;
        6: cap_v = 5'd3;
        7: cap_v = 5'd16;
        8: cap_v = 5'd2;
        default: cap_v = 5'($urandom_range(31));
      endcase
      write_capacity(cap_v);
      idle_pct = (p == 7) ? 0 : 27;
      for (int i = 2; i < 6; i++) value_pool[i] = $urandom;
      for (int k = 0; k < PhaseOps; k++) begin
        while (feed_q.size() >= 2) @(posedge clk_i);
        feed_q.push_back(random_request());
      end
    end
    wait_idle();

    $display("Ran %0d directed and %0d random operations over %0d capacity writes.",
             n_directed, RandPhases * PhaseOps, n_cap_writes);
    $display("Checked %0d results: %0d find hits, %0d rejected, %0d errors.",
             n_checked, n_hits, n_rejected, errors);
    if (errors == 0) begin
      $display("bounded_vector_store_core: match");
    end else begin
      $display("bounded_vector_store_core: mismatch");
    end
    $finish;
  end

endmodule
